// ===== src/twwf_pkg.sv =====
// Package: shared types, constants and the weight table of the trimmed window filter.
`default_nettype none
package twwf_pkg;
	localparam int unsigned SampleW = 16;
	localparam int unsigned TrimCount = 4;
	localparam int unsigned WeightTableSize = 64;
	localparam int unsigned WeightW = 9;

	typedef logic [SampleW-1:0] sample_t;
	typedef logic [WeightW-1:0] weight_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACC,
		ST_DIV,
		ST_OUT
	} back_state_t;

	function automatic weight_t weight_lookup(input logic [5:0] idx);
		weight_t w;
		unique case (idx)
			6'd0, 6'd1, 6'd2, 6'd3, 6'd4: w = 9'd1;
			6'd5, 6'd6, 6'd7, 6'd8, 6'd9: w = 9'd2;
			6'd10, 6'd11, 6'd12, 6'd13: w = 9'd3;
			6'd14, 6'd15: w = 9'd4;
			6'd16, 6'd17: w = 9'd5;
			6'd18, 6'd19: w = 9'd6;
			6'd20, 6'd21: w = 9'd7;
			6'd22: w = 9'd8;
			6'd23: w = 9'd9;
			6'd24: w = 9'd10;
			6'd25: w = 9'd11;
			6'd26: w = 9'd12;
			6'd27: w = 9'd13;
			6'd28: w = 9'd14;
			6'd29: w = 9'd16;
			6'd30: w = 9'd17;
			6'd31: w = 9'd19;
			6'd32: w = 9'd21;
			6'd33: w = 9'd23;
			6'd34: w = 9'd26;
			6'd35: w = 9'd28;
			6'd36: w = 9'd31;
			6'd37: w = 9'd34;
			6'd38: w = 9'd37;
			6'd39: w = 9'd41;
			6'd40: w = 9'd45;
			6'd41: w = 9'd50;
			6'd42: w = 9'd55;
			6'd43: w = 9'd60;
			6'd44: w = 9'd66;
			6'd45: w = 9'd73;
			6'd46: w = 9'd80;
			6'd47: w = 9'd88;
			6'd48: w = 9'd97;
			6'd49: w = 9'd107;
			6'd50: w = 9'd117;
			6'd51: w = 9'd129;
			6'd52: w = 9'd142;
			6'd53: w = 9'd156;
			6'd54: w = 9'd172;
			6'd55: w = 9'd189;
			6'd56: w = 9'd208;
			6'd57: w = 9'd229;
			6'd58: w = 9'd252;
			6'd59: w = 9'd277;
			6'd60: w = 9'd304;
			6'd61: w = 9'd335;
			6'd62: w = 9'd368;
			default: w = 9'd405;
		endcase
		return w;
	endfunction
endpackage
`default_nettype wire

// ===== src/twwf_stream_if.sv =====
// Interfaces: valid/ready channels for input and result words.
`default_nettype none
interface twwf_in_if;
	logic valid;
	logic ready;
	logic [15:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface twwf_out_if;
	logic valid;
	logic ready;
	logic [15:0] filtered_value;
	logic fallback_used;
	modport source (output valid, output filtered_value, output fallback_used, input ready);
	modport sink (input valid, input filtered_value, input fallback_used, output ready);
endinterface
`default_nettype wire

// ===== src/twwf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module twwf_ram #(
	parameter int unsigned Width = 16,
	parameter int unsigned Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(Depth)-1:0] wr_addr,
	input  wire logic [Width-1:0]         wr_data,
	input  wire logic [$clog2(Depth)-1:0] rd_addr,
	output logic      [Width-1:0]         rd_data
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

// ===== src/twwf_queue.sv =====
// Two-entry queue of samples between the front and the back part.
`default_nettype none
module twwf_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire twwf_pkg::sample_t push_data,
	output logic                   full,
	input  wire logic              pop,
	output logic                   not_empty,
	output twwf_pkg::sample_t      head
);
	import twwf_pkg::*;

	sample_t    data_q [2];
	logic       rd_q;
	logic       wr_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head = data_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// ===== src/twwf_back.sv =====
// Back part: window store, extreme search, weighted sum and serial divide.
`default_nettype none
module twwf_back #(
	parameter int unsigned WindowDepth = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire twwf_pkg::sample_t q_data,
	output logic                   q_pop,
	twwf_out_if.source             res
);
	import twwf_pkg::*;

	localparam int unsigned AddrW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
	localparam int unsigned CntW = $clog2(WindowDepth + 1);
	localparam int unsigned WtotW = WeightW + 6;
	localparam int unsigned SumW = SampleW + WtotW;
	localparam int unsigned DivCntW = $clog2(SumW + 1);

	back_state_t state_q, state_d;
	logic [AddrW-1:0] wslot_q;
	logic [CntW-1:0]  count_q;
	logic [AddrW-1:0] start_q;
	logic [CntW-1:0]  iter_q;
	sample_t          newest_q;
	sample_t          mins_q [TrimCount];
	sample_t          maxs_q [TrimCount];
	logic [SumW-1:0]  wsum_q;
	logic [WtotW-1:0] wtot_q;
	logic [5:0]       kept_q;
	logic [SumW-1:0]  quo_q;
	logic [WtotW:0]   rem_q;
	logic [DivCntW-1:0] dcnt_q;
	logic             fb_q;
	logic             rd_valid_s1;
	logic [AddrW-1:0] rd_addr;
	sample_t          rd_data;
	logic [AddrW-1:0] ram_addr;
	logic             wr_en;
	logic             out_valid_q;
	sample_t          out_val_q;
	logic             out_fb_q;

	twwf_ram #(.Width(SampleW), .Depth(1 << AddrW)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wslot_q),
		.wr_data (q_data),
		.rd_addr (ram_addr),
		.rd_data (rd_data)
	);

	function automatic logic [AddrW-1:0] wrap_inc(input logic [AddrW-1:0] a);
		logic [AddrW:0] n;
		n = {1'b0, a} + 1'b1;
		if (n >= (AddrW + 1)'(WindowDepth)) n = '0;
		return n[AddrW-1:0];
	endfunction

	logic at_end;
	logic [AddrW:0] addr_sum;
	logic drop;
	logic [WtotW:0] trial;
	weight_t w;
	logic [SumW-1:0] prod;

	assign at_end = iter_q == count_q;
	assign addr_sum = {1'b0, start_q} + {1'b0, iter_q[AddrW-1:0]};
	assign rd_addr = (addr_sum >= (AddrW + 1)'(WindowDepth)) ?
		AddrW'(addr_sum - (AddrW + 1)'(WindowDepth)) : addr_sum[AddrW-1:0];
	assign ram_addr = rd_addr;
	assign wr_en = (state_q == ST_IDLE) && q_valid;
	assign w = weight_lookup(kept_q);
	assign prod = SumW'(rd_data) * SumW'(w);
	assign trial = {rem_q[WtotW-1:0], quo_q[SumW-1]};

	always_comb begin
		drop = 1'b0;
		for (int j = 0; j < TrimCount; j++) begin
			if (rd_data == mins_q[j] || rd_data == maxs_q[j]) drop = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (q_valid) state_d = ST_SCAN;
			ST_SCAN: if (rd_valid_s1 && at_end) state_d = ST_ACC;
			ST_ACC: if (rd_valid_s1 && at_end) state_d = (wtot_q == '0 && drop) ?
				ST_OUT : ST_DIV;
			ST_DIV: if (dcnt_q == '0) state_d = ST_OUT;
			ST_OUT: if (!out_valid_q || res.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == ST_IDLE) && q_valid;
	end

	assign res.valid = out_valid_q;
	assign res.filtered_value = out_val_q;
	assign res.fallback_used = out_fb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wslot_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				wslot_q <= wrap_inc(wslot_q);
				if (count_q != CntW'(WindowDepth)) count_q <= count_q + 1'b1;
			end
			if (state_q == ST_OUT && (!out_valid_q || res.ready)) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				newest_q <= q_data;
				iter_q <= '0;
				rd_valid_s1 <= 1'b0;
				wsum_q <= '0;
				wtot_q <= '0;
				kept_q <= '0;
				for (int j = 0; j < TrimCount; j++) begin
					mins_q[j] <= '1;
					maxs_q[j] <= '0;
				end
				begin
					logic [CntW:0] c;
					logic [CntW:0] s;
					c = (count_q != CntW'(WindowDepth)) ? {1'b0, count_q} + 1'b1
						: {1'b0, count_q};
					s = (CntW + 1)'(wrap_inc(wslot_q)) + (CntW + 1)'(WindowDepth) - c;
					if (s >= (CntW + 1)'(WindowDepth)) s = s - (CntW + 1)'(WindowDepth);
					start_q <= AddrW'(s);
				end
			end
			ST_SCAN: begin
				rd_valid_s1 <= !at_end;
				if (!at_end) iter_q <= iter_q + 1'b1;
				if (rd_valid_s1) begin
					priority if (rd_data < mins_q[0]) begin
						mins_q[0] <= rd_data; mins_q[1] <= mins_q[0];
						mins_q[2] <= mins_q[1]; mins_q[3] <= mins_q[2];
					end else if (rd_data < mins_q[1]) begin
						mins_q[1] <= rd_data; mins_q[2] <= mins_q[1]; mins_q[3] <= mins_q[2];
					end else if (rd_data < mins_q[2]) begin
						mins_q[2] <= rd_data; mins_q[3] <= mins_q[2];
					end else if (rd_data < mins_q[3]) begin
						mins_q[3] <= rd_data;
					end
					priority if (rd_data > maxs_q[0]) begin
						maxs_q[0] <= rd_data; maxs_q[1] <= maxs_q[0];
						maxs_q[2] <= maxs_q[1]; maxs_q[3] <= maxs_q[2];
					end else if (rd_data > maxs_q[1]) begin
						maxs_q[1] <= rd_data; maxs_q[2] <= maxs_q[1]; maxs_q[3] <= maxs_q[2];
					end else if (rd_data > maxs_q[2]) begin
						maxs_q[2] <= rd_data; maxs_q[3] <= maxs_q[2];
					end else if (rd_data > maxs_q[3]) begin
						maxs_q[3] <= rd_data;
					end
				end
				if (rd_valid_s1 && at_end) begin
					iter_q <= '0;
				end
			end
			ST_ACC: begin
				rd_valid_s1 <= !at_end;
				if (!at_end) iter_q <= iter_q + 1'b1;
				if (rd_valid_s1 && !drop) begin
					wsum_q <= wsum_q + prod;
					wtot_q <= wtot_q + WtotW'(w);
					kept_q <= kept_q + 1'b1;
				end
				if (rd_valid_s1 && at_end) begin
					quo_q <= drop ? wsum_q : wsum_q + prod;
					rem_q <= '0;
					dcnt_q <= DivCntW'(SumW);
					fb_q <= drop && wtot_q == '0;
				end
			end
			ST_DIV: begin
				if (dcnt_q != '0) begin
					dcnt_q <= dcnt_q - 1'b1;
					if (trial >= {1'b0, wtot_q}) begin
						rem_q <= trial - {1'b0, wtot_q};
						quo_q <= {quo_q[SumW-2:0], 1'b1};
					end else begin
						rem_q <= trial;
						quo_q <= {quo_q[SumW-2:0], 1'b0};
					end
				end
			end
			ST_OUT: begin
				if (!out_valid_q || res.ready) begin
					out_val_q <= fb_q ? newest_q : quo_q[SampleW-1:0];
					out_fb_q <= fb_q;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/twwf_front.sv =====
// Front part: accept sample words and push them into the queue.
`default_nettype none
module twwf_front (
	twwf_in_if.sink           in,
	input  wire logic         q_full,
	output logic              q_push,
	output twwf_pkg::sample_t q_data
);
	import twwf_pkg::*;

	assign in.ready = !q_full;
	assign q_push = in.valid && !q_full;
	assign q_data = in.sample;
endmodule
`default_nettype wire

// ===== src/trimmed_weighted_window_filter_top.sv =====
// Top level of the trimmed weighted window filter.
`default_nettype none
// Each sample word is written into a ring window of the last WINDOW_DEPTH samples,
// the four smallest and four largest values are found, every sample equal to one
// of them is dropped, and the rest are averaged with weights round(1.1^k). One
// result word per sample. Each item makes two passes over the single-read-port
// window RAM, then runs 31 divide steps of a restoring divider, one quotient bit
// a cycle; the divide is skipped when every sample is dropped. The back part
// takes no new sample until it has finished the last one, and it stalls while
// a result word is still waiting. A two-word queue decouples input.
module trimmed_weighted_window_filter_top #(
	parameter int unsigned WINDOW_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	twwf_in_if.sink   in,
	twwf_out_if.source out
);
	import twwf_pkg::*;

	logic    q_full, q_push, q_pop, q_ne;
	sample_t q_in, q_head;

	twwf_front u_front (
		.in (in),
		.q_full (q_full), .q_push (q_push), .q_data (q_in)
	);

	twwf_queue u_queue (
		.clk (clk), .arst_n (arst_n), .push (q_push), .push_data (q_in),
		.full (q_full), .pop (q_pop), .not_empty (q_ne), .head (q_head)
	);

	twwf_back #(.WindowDepth(WINDOW_DEPTH)) u_back (
		.clk (clk), .arst_n (arst_n), .q_valid (q_ne), .q_data (q_head),
		.q_pop (q_pop), .res (out)
	);

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_ne) else $error("queue popped while empty");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("queue pushed while full");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid) else $error("result word lost");
`endif
endmodule
`default_nettype wire
